/* src/framed_serial_command_receiver_macros.svh */
// assertion macros shared by the framed serial command receiver sources
// expects i_clk and i_rst_n (synchronous, active low) in the including module
`ifndef FRAMED_SERIAL_COMMAND_RECEIVER_MACROS_SVH
`define FRAMED_SERIAL_COMMAND_RECEIVER_MACROS_SVH

// condition holds at every clock edge outside reset
`define FSCR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// condition in one cycle implies the outcome in the next
`define FSCR_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

/* src/fscr_pkg.sv */
// shared types and byte codes for the framed serial command receiver
// no dependencies; imported by fscr_parser, the top level and the testbench
package fscr_pkg;

    // framing and reply byte codes
    localparam logic [7:0] SYN_BYTE = 8'hFA;
    localparam logic [7:0] STX_BYTE = 8'hFD;
    localparam logic [7:0] ETX_BYTE = 8'hFE;
    localparam logic [7:0] ACK_BYTE = 8'hEF;
    localparam logic [7:0] NAK_BYTE = 8'hEE;

    // default receive buffer size in bytes
    localparam int BUFFER_BYTES_DEF = 256;

    // result kinds as carried on tuser
    typedef enum logic [1:0] {
        KIND_DATA   = 2'd0,
        KIND_ACCEPT = 2'd1,
        KIND_REJECT = 2'd2
    } t_kind;

    // one result word
    typedef struct packed {
        logic [7:0] reply_byte;
        logic [7:0] data_position;
        logic [7:0] data_value;
        logic [7:0] frame_length;
        logic [7:0] frame_subcommand;
        logic [7:0] frame_command;
        t_kind      kind;
    } t_result;

endpackage

/* src/fscr_parser.sv */
// frame parser: hunt, header, length, data, checksum and closing byte
// uses fscr_pkg and the assertion macros header
`include "framed_serial_command_receiver_macros.svh"

module fscr_parser #(
    parameter int BUFFER_BYTES = fscr_pkg::BUFFER_BYTES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    output logic              o_res_valid,
    output fscr_pkg::t_result o_res
);
    import fscr_pkg::*;

    localparam int LEN_W   = 16;
    localparam int MAX_LEN = BUFFER_BYTES - 9;
    localparam int CNT_W   = $clog2(MAX_LEN);

    typedef enum logic [2:0] {
        PH_HUNT   = 3'd0,
        PH_CMD    = 3'd1,
        PH_SUB    = 3'd2,
        PH_LEN_LO = 3'd3,
        PH_LEN_HI = 3'd4,
        PH_DATA   = 3'd5,
        PH_CSUM   = 3'd6,
        PH_CLOSE  = 3'd7
    } t_phase;

    t_phase             r_phase, n_phase;
    logic               r_prev_sync;
    logic               r_csum_hi, n_csum_hi;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [7:0]         r_cmd, n_cmd;
    logic [7:0]         r_sub, n_sub;
    logic [LEN_W-1:0]   r_len, n_len;
    logic [LEN_W-1:0]   r_xor, n_xor;
    logic [LEN_W-1:0]   r_sum, n_sum;

    logic               restart;
    logic [LEN_W-1:0]   len_full;
    logic [LEN_W-1:0]   cnt_next_ext;
    logic [CNT_W+7:0]   pos_wide;

    assign restart      = r_prev_sync && (i_byte == STX_BYTE);
    assign len_full     = {i_byte, r_len[7:0]};
    assign cnt_next_ext = LEN_W'(r_cnt) + LEN_W'(1);
    assign pos_wide     = {8'b0, r_cnt};

    // next state and result for the byte on the input
    always_comb begin
        n_phase     = r_phase;
        n_csum_hi   = r_csum_hi;
        n_cnt       = r_cnt;
        n_cmd       = r_cmd;
        n_sub       = r_sub;
        n_len       = r_len;
        n_xor       = r_xor;
        n_sum       = r_sum;
        o_res_valid = 1'b0;
        o_res.kind             = KIND_DATA;
        o_res.frame_command    = r_cmd;
        o_res.frame_subcommand = r_sub;
        o_res.frame_length     = r_len[7:0];
        o_res.data_value       = 8'd0;
        o_res.data_position    = 8'd0;
        o_res.reply_byte       = 8'd0;

        if (restart) begin
            n_phase   = PH_CMD;
            n_cnt     = '0;
            n_csum_hi = 1'b0;
            n_xor     = '0;
            n_sum     = '0;
        end else begin
            case (r_phase)
                PH_HUNT: begin
                    n_phase = PH_HUNT;
                end
                PH_CMD: begin
                    n_cmd   = i_byte;
                    n_xor   = LEN_W'(i_byte);
                    n_phase = PH_SUB;
                end
                PH_SUB: begin
                    n_sub   = i_byte;
                    n_xor   = r_xor ^ LEN_W'(i_byte);
                    n_phase = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    n_len   = LEN_W'(i_byte);
                    n_phase = PH_LEN_HI;
                end
                PH_LEN_HI: begin
                    n_len = len_full;
                    if (len_full > LEN_W'(MAX_LEN)) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_xor     = r_xor ^ len_full;
                        n_cnt     = '0;
                        n_csum_hi = 1'b0;
                        n_phase   = (len_full != '0) ? PH_DATA : PH_CSUM;
                    end
                end
                PH_DATA: begin
                    n_xor                = r_xor ^ LEN_W'(i_byte);
                    o_res_valid          = 1'b1;
                    o_res.kind           = KIND_DATA;
                    o_res.data_value     = i_byte;
                    o_res.data_position  = pos_wide[7:0];
                    if (cnt_next_ext >= r_len) begin
                        n_cnt   = '0;
                        n_phase = PH_CSUM;
                    end else begin
                        n_cnt = r_cnt + CNT_W'(1);
                    end
                end
                PH_CSUM: begin
                    if (!r_csum_hi) begin
                        n_sum     = LEN_W'(i_byte);
                        n_csum_hi = 1'b1;
                    end else begin
                        n_sum     = {i_byte, r_sum[7:0]};
                        n_csum_hi = 1'b0;
                        n_phase   = PH_CLOSE;
                    end
                end
                PH_CLOSE: begin
                    o_res_valid = 1'b1;
                    if ((r_sum == r_xor) && (i_byte == ETX_BYTE)) begin
                        o_res.kind       = KIND_ACCEPT;
                        o_res.reply_byte = ACK_BYTE;
                    end else begin
                        o_res.kind       = KIND_REJECT;
                        o_res.reply_byte = NAK_BYTE;
                    end
                    n_phase = PH_HUNT;
                end
                default: begin
                    n_phase = PH_HUNT;
                end
            endcase
        end
    end

    // state update on each accepted word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HUNT;
            r_prev_sync <= 1'b0;
            r_csum_hi   <= 1'b0;
            r_cnt       <= '0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_prev_sync <= (i_byte == SYN_BYTE);
            r_csum_hi   <= n_csum_hi;
            r_cnt       <= n_cnt;
        end
    end

    // frame fields and checksums
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmd <= '0;
            r_sub <= '0;
            r_len <= '0;
            r_xor <= '0;
            r_sum <= '0;
        end else if (i_accept) begin
            r_cmd <= n_cmd;
            r_sub <= n_sub;
            r_len <= n_len;
            r_xor <= n_xor;
            r_sum <= n_sum;
        end
    end

    // checks
    `FSCR_ASSERT_NEXT(a_restart_to_cmd,
        i_accept && restart,
        r_phase == PH_CMD,
        "SYN STX did not restart framing")
    `FSCR_ASSERT_ALWAYS(a_cnt_below_len,
        (r_phase != PH_DATA) || (LEN_W'(r_cnt) < r_len),
        "data counter reached declared length")
    `FSCR_ASSERT_NEXT(a_oversize_drop,
        i_accept && !restart && (r_phase == PH_LEN_HI) && (len_full > LEN_W'(MAX_LEN)),
        r_phase == PH_HUNT,
        "oversized frame not dropped")

endmodule

/* src/framed_serial_command_receiver.sv */
// top level of the framed serial command receiver: stream ports and result register
// depends on fscr_pkg and fscr_parser
//
//  channel   direction  payload
//  s_axis    in         tdata: rx_byte
//  m_axis    out        tuser: kind; tdata: command, subcommand, length, value,
//                       position, reply
//
// one received byte is taken per cycle while no result is stalled; the parser decides in the same cycle
// and a data byte or verdict is written into the result register at the clock edge that takes the byte
// synchronous active-low reset returns the parser to hunting for SYN STX
// a stalled result holds the input side until it is taken; a new byte can be taken in that same cycle

module framed_serial_command_receiver #(
    parameter int BUFFER_BYTES = fscr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [7:0]  i_s_axis_tdata,   // [7:0] rx_byte
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [47:0] o_m_axis_tdata,   // [7:0] frame_command, [15:8] frame_subcommand,
                                          // [23:16] frame_length, [31:24] data_value,
                                          // [39:32] data_position, [47:40] reply_byte
    output logic [1:0]  o_m_axis_tuser    // [1:0] kind
);
    import fscr_pkg::*;

    logic    in_accept;
    logic    res_valid;
    t_result res;
    logic    r_valid;
    t_result r_res;

    assign o_s_axis_tready = !r_valid || i_m_axis_tready;
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;

    fscr_parser #(
        .BUFFER_BYTES (BUFFER_BYTES)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // result register valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_valid <= in_accept && res_valid;
        end
    end

    // result word
    always_ff @(posedge i_clk) begin
        if (in_accept && res_valid) begin
            r_res <= res;
        end
    end

    assign o_m_axis_tvalid = r_valid;
    assign o_m_axis_tuser  = r_res.kind;
    assign o_m_axis_tdata  = {r_res.reply_byte, r_res.data_position, r_res.data_value,
                              r_res.frame_length, r_res.frame_subcommand,
                              r_res.frame_command};

endmodule

/* tb/sv/fscr_frame_checker.sv */
// result checker for the framed serial command receiver testbench
// depends on fscr_pkg; watches both stream channels, predicts each result word and compares
`timescale 1ns / 1ps

module fscr_frame_checker #(
    parameter int BUFFER_BYTES = fscr_pkg::BUFFER_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_rx_valid,
    input  logic        i_rx_ready,
    input  logic [7:0]  i_rx_byte,      // [7:0] rx_byte
    input  logic        i_res_valid,
    input  logic        i_res_ready,
    input  logic [47:0] i_res_data,     // [7:0] command, [15:8] subcommand, [23:16] length,
                                        // [31:24] value, [39:32] position, [47:40] reply
    input  logic [1:0]  i_res_user,     // [1:0] kind
    output int          o_fail_count,
    output int          o_pending,
    output int          o_data_words,
    output int          o_accepts,
    output int          o_rejects
);
    import fscr_pkg::*;

    localparam int MAX_LEN = BUFFER_BYTES - 9;

    // framing phases of the receiver
    typedef enum logic [2:0] {
        PH_HUNT,
        PH_CMD,
        PH_SUB,
        PH_LEN_LO,
        PH_LEN_HI,
        PH_DATA,
        PH_CSUM,
        PH_CLOSE
    } t_phase;

    // predicted receiver state
    t_phase      phase;
    logic        prev_syn;
    logic [7:0]  cmd_q;
    logic [7:0]  sub_q;
    logic [15:0] len_q;
    int          count_q;
    logic [15:0] xor_q;
    logic [15:0] csum_q;

    // words still owed by the block, oldest first
    t_result     owed_words[$];
    int          words_checked;

    // one line per mismatch, and count it
    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("[%0t] word %0d: %s got %0h expected %0h", $time, words_checked, what,
                 got, want);
        o_fail_count++;
    endtask

    function automatic t_result framed_word(input t_kind k, input logic [7:0] value,
                                            input logic [7:0] pos, input logic [7:0] reply);
        t_result r;
        r.kind             = k;
        r.frame_command    = cmd_q;
        r.frame_subcommand = sub_q;
        r.frame_length     = len_q[7:0];
        r.data_value       = value;
        r.data_position    = pos;
        r.reply_byte       = reply;
        return r;
    endfunction

    // advance the framing state by one received byte, queue any word it gives
    function automatic void frame_byte_outcome(input logic [7:0] b);
        logic syn_seen;
        syn_seen = prev_syn;
        prev_syn = (b == SYN_BYTE);
        // syn then stx restarts framing from anywhere
        if (syn_seen && b == STX_BYTE) begin
            phase   = PH_CMD;
            count_q = 0;
            xor_q   = '0;
            csum_q  = '0;
            return;
        end
        case (phase)
            PH_CMD: begin
                cmd_q = b;
                xor_q = {8'h00, b};
                phase = PH_SUB;
            end
            PH_SUB: begin
                sub_q = b;
                xor_q ^= {8'h00, b};
                phase = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                len_q = {8'h00, b};
                phase = PH_LEN_HI;
            end
            PH_LEN_HI: begin
                len_q[15:8] = b;
                // oversized frames are dropped without a word
                if (int'(len_q) > MAX_LEN) begin
                    phase = PH_HUNT;
                end else begin
                    xor_q ^= len_q;
                    count_q = 0;
                    phase = (len_q != 0) ? PH_DATA : PH_CSUM;
                end
            end
            PH_DATA: begin
                xor_q ^= {8'h00, b};
                owed_words.push_back(framed_word(KIND_DATA, b, 8'(count_q), 8'h00));
                count_q++;
                if (count_q >= int'(len_q)) begin
                    count_q = 0;
                    phase = PH_CSUM;
                end
            end
            PH_CSUM: begin
                if (count_q == 0) begin
                    csum_q  = {8'h00, b};
                    count_q = 1;
                end else begin
                    csum_q[15:8] = b;
                    count_q = 0;
                    phase = PH_CLOSE;
                end
            end
            PH_CLOSE: begin
                if (csum_q == xor_q && b == ETX_BYTE)
                    owed_words.push_back(framed_word(KIND_ACCEPT, 8'h00, 8'h00, ACK_BYTE));
                else
                    owed_words.push_back(framed_word(KIND_REJECT, 8'h00, 8'h00, NAK_BYTE));
                phase = PH_HUNT;
            end
            default: phase = PH_HUNT;
        endcase
    endfunction

    // result words first: any accepted now came from bytes taken earlier
    always @(posedge i_clk) begin : watch
        t_result want;
        if (!i_rst_n) begin
            phase    = PH_HUNT;
            prev_syn = 1'b0;
            cmd_q    = '0;
            sub_q    = '0;
            len_q    = '0;
            count_q  = 0;
            xor_q    = '0;
            csum_q   = '0;
            owed_words.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (owed_words.size() == 0) begin
                    report_mismatch("word with none owed, kind", {6'b0, i_res_user}, 8'h00);
                end else begin
                    want = owed_words.pop_front();
                    if (i_res_user !== want.kind)
                        report_mismatch("kind", {6'b0, i_res_user}, {6'b0, want.kind});
                    if (i_res_data[7:0] !== want.frame_command)
                        report_mismatch("command", i_res_data[7:0], want.frame_command);
                    if (i_res_data[15:8] !== want.frame_subcommand)
                        report_mismatch("subcommand", i_res_data[15:8], want.frame_subcommand);
                    if (i_res_data[23:16] !== want.frame_length)
                        report_mismatch("length", i_res_data[23:16], want.frame_length);
                    if (i_res_data[31:24] !== want.data_value)
                        report_mismatch("value", i_res_data[31:24], want.data_value);
                    if (i_res_data[39:32] !== want.data_position)
                        report_mismatch("position", i_res_data[39:32], want.data_position);
                    if (i_res_data[47:40] !== want.reply_byte)
                        report_mismatch("reply", i_res_data[47:40], want.reply_byte);
                    case (want.kind)
                        KIND_DATA:   o_data_words++;
                        KIND_ACCEPT: o_accepts++;
                        default:     o_rejects++;
                    endcase
                end
                words_checked++;
            end
            if (i_rx_valid && i_rx_ready)
                frame_byte_outcome(i_rx_byte);
        end
        o_pending = owed_words.size();
    end

endmodule

/* tb/sv/tb_top.sv */
// top of the framed serial command receiver testbench: clock, reset, byte stimulus and verdict
// depends on fscr_pkg, framed_serial_command_receiver and fscr_frame_checker
`timescale 1ns / 1ps

module tb_top;
    import fscr_pkg::*;

    localparam int MAX_LEN      = BUFFER_BYTES_DEF - 9;
    localparam int TARGET_BYTES = 1050;

    // ways a sent frame is spoilt
    typedef enum int {
        FLAW_NONE,
        FLAW_SUM_LO,
        FLAW_SUM_HI,
        FLAW_ETX,
        FLAW_CUT
    } t_flaw;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [47:0] m_axis_tdata;
    logic [1:0]  m_axis_tuser;

    int fail_count;
    int pending;
    int data_words;
    int accepts;
    int rejects;

    // stimulus bookkeeping and idling control
    int   payload_bytes;
    int   frames_sent;
    int   oversized_sent;
    int   cut_sent;
    int   bad_sent;
    int   hold_cycles;
    logic tx_idle_on;
    logic rx_stall_on;

    // clock
    initial begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    framed_serial_command_receiver u_top (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_axis_tvalid),
        .o_s_axis_tready (s_axis_tready),
        .i_s_axis_tdata  (s_axis_tdata),
        .o_m_axis_tvalid (m_axis_tvalid),
        .i_m_axis_tready (m_axis_tready),
        .o_m_axis_tdata  (m_axis_tdata),
        .o_m_axis_tuser  (m_axis_tuser)
    );

    fscr_frame_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_rx_valid   (s_axis_tvalid),
        .i_rx_ready   (s_axis_tready),
        .i_rx_byte    (s_axis_tdata),
        .i_res_valid  (m_axis_tvalid),
        .i_res_ready  (m_axis_tready),
        .i_res_data   (m_axis_tdata),
        .i_res_user   (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_data_words (data_words),
        .o_accepts    (accepts),
        .o_rejects    (rejects)
    );

    // offer one byte, after a random gap when idling is on, and wait for it to be taken
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, 17) : 0;
        if (gap > 0) begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
    endtask

    // withdraw the byte offer and wait until every owed word is out
    task automatic pause_until_drained();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        wait (pending == 0);
    endtask

    // bytes biased towards the framing codes
    task automatic send_noise(input int n);
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 3))
                0:       send_byte(SYN_BYTE);
                1:       send_byte(STX_BYTE);
                2:       send_byte(ETX_BYTE);
                default: send_byte(8'($urandom));
            endcase
        end
    endtask

    // build a frame with a correct checksum, spoil it as asked; oversized ones send the header only
    task automatic send_frame(input logic [7:0] cmd, input logic [7:0] sub,
                              input logic [15:0] len, input t_flaw flaw, input int fill);
        logic [7:0]  q[$];
        logic [15:0] csum;
        logic [7:0]  d;
        int          keep;
        q = {SYN_BYTE, STX_BYTE, cmd, sub, len[7:0], len[15:8]};
        frames_sent++;
        if (int'(len) > MAX_LEN) begin
            oversized_sent++;
        end else begin
            csum = {8'h00, cmd} ^ {8'h00, sub} ^ len;
            for (int i = 0; i < int'(len); i++) begin
                d = (fill < 0) ? 8'($urandom) : fill[7:0];
                q.push_back(d);
                csum ^= {8'h00, d};
            end
            case (flaw)
                FLAW_SUM_LO: csum[7:0]  ^= 8'($urandom_range(1, 255));
                FLAW_SUM_HI: csum[15:8] ^= 8'($urandom_range(1, 255));
                default: ;
            endcase
            q.push_back(csum[7:0]);
            q.push_back(csum[15:8]);
            d = ETX_BYTE;
            while (flaw == FLAW_ETX && d == ETX_BYTE) d = 8'($urandom);
            q.push_back(d);
            if (flaw == FLAW_CUT) begin
                keep = $urandom_range(3, q.size() - 1);
                while (q.size() > keep) void'(q.pop_back());
                cut_sent++;
            end else if (flaw != FLAW_NONE) begin
                bad_sent++;
            end
        end
        payload_bytes += q.size();
        foreach (q[i]) send_byte(q[i]);
    endtask

    // result side: random stall per word, plus a long hold-off on request
    initial begin : result_sink
        int w;
        m_axis_tready = 1'b0;
        wait (rst_n);
        forever begin
            w = (hold_cycles > 0) ? hold_cycles : (rx_stall_on ? $urandom_range(0, 17) : 0);
            hold_cycles = 0;
            if (w > 0) begin
                @(negedge clk);
                m_axis_tready <= 1'b0;
                repeat (w - 1) @(negedge clk);
            end
            @(negedge clk);
            m_axis_tready <= 1'b1;
            @(posedge clk);
            while (!m_axis_tvalid && hold_cycles == 0) @(posedge clk);
            if ($urandom_range(0, 63) == 0) rx_stall_on = ~rx_stall_on;
        end
    end

    // stimulus and verdict
    initial begin : stimulus
        int          frame_no;
        int          pick;
        logic [15:0] len;
        t_flaw       flaw;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'h00;
        tx_idle_on    = 1'b1;
        rx_stall_on   = 1'b1;
        hold_cycles   = 0;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;

        // directed: extremes of the header, each verdict, drops and restarts
        send_noise(3);
        send_frame(8'h00, 8'hFF, 16'd0, FLAW_NONE, -1);
        send_frame(8'hFF, 8'h00, 16'd1, FLAW_SUM_HI, 0);
        send_frame(8'hA5, 8'h5A, 16'd1, FLAW_ETX, 255);
        send_frame(8'h12, 8'h34, 16'(MAX_LEN + 1), FLAW_NONE, -1);
        send_frame(8'h56, 8'h78, 16'hFFFF, FLAW_NONE, -1);
        send_frame(8'h9A, 8'hBC, 16'd4, FLAW_CUT, -1);
        send_byte(SYN_BYTE);
        send_frame(8'h01, 8'h02, 16'd2, FLAW_SUM_LO, -1);
        pause_until_drained();

        // random: mostly well-formed short frames, the rest broken frames and noise
        frame_no = 0;
        while (payload_bytes < TARGET_BYTES) begin
            tx_idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            flaw = FLAW_NONE;
            pick = $urandom_range(0, 99);
            if (pick < 85)      len = 16'($urandom_range(0, 12));
            else if (pick < 98) len = 16'($urandom_range(13, 64));
            else                len = 16'($urandom_range(65, MAX_LEN));
            pick = $urandom_range(0, 99);
            if (pick >= 95) begin
                send_noise($urandom_range(1, 8));
            end else begin
                if (pick >= 90)
                    len = ($urandom_range(0, 3) == 0) ? 16'(MAX_LEN + 1)
                                                      : 16'($urandom_range(MAX_LEN + 1, 65535));
                else if (pick >= 85) flaw = FLAW_CUT;
                else if (pick >= 80) flaw = FLAW_ETX;
                else if (pick >= 75) flaw = FLAW_SUM_HI;
                else if (pick >= 70) flaw = FLAW_SUM_LO;
                // one frame of the largest length the buffer allows
                if (frame_no == 4) begin
                    len  = 16'(MAX_LEN);
                    flaw = FLAW_NONE;
                end
                // long hold-off on results while bytes keep coming back to back
                if (frame_no == 8) begin
                    tx_idle_on  = 1'b0;
                    hold_cycles = 300;
                    len         = 16'd60;
                    flaw        = FLAW_NONE;
                end
                send_frame(8'($urandom), 8'($urandom), len, flaw, -1);
            end
            frame_no++;
            // pause until every owed word is out
            if (frame_no % 20 == 0) pause_until_drained();
        end

        pause_until_drained();
        repeat (20) @(posedge clk);

        $display("sent %0d frame bytes in %0d frames: %0d oversized, %0d cut short, %0d spoilt",
                 payload_bytes, frames_sent, oversized_sent, cut_sent, bad_sent);
        $display("checked %0d data words, %0d accepted and %0d rejected frames",
                 data_words, accepts, rejects);
        if (fail_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    // overall time limit
    initial begin : watchdog
        #5_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

/* framed_serial_command_receiver.f */
+incdir+src
src/fscr_pkg.sv
src/fscr_parser.sv
src/framed_serial_command_receiver.sv
tb/sv/fscr_frame_checker.sv
tb/sv/tb_top.sv
